[src/cti_pkg.sv]
// Shared types, codes and saturation helper for the cubic trajectory interpolator.
package cti_pkg;

  localparam int DataW  = 32;
  localparam int AddrW  = 4;
  localparam int NumCoef = 8;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_TICK_PERIOD   = 2'd0;
  localparam logic [1:0] REG_HIT_TIME      = 2'd1;
  localparam logic [1:0] REG_RETURN_TIME   = 2'd2;
  localparam logic [1:0] REG_REST_POSITION = 2'd3;

  localparam logic [31:0] TICK_PERIOD_RST   = 32'd33554;
  localparam logic [31:0] HIT_TIME_RST      = 32'd8388608;
  localparam logic [31:0] RETURN_TIME_RST   = 32'd16777216;
  localparam logic [31:0] REST_POSITION_RST = 32'd0;

  // Output phase codes
  localparam logic [1:0] PHASE_HIT  = 2'd0;
  localparam logic [1:0] PHASE_RET  = 2'd1;
  localparam logic [1:0] PHASE_REST = 2'd2;

  // Multiply-accumulate step codes
  localparam logic [2:0] OP_POS_A = 3'd0;
  localparam logic [2:0] OP_POS_B = 3'd1;
  localparam logic [2:0] OP_POS_C = 3'd2;
  localparam logic [2:0] OP_VEL_A = 3'd3;
  localparam logic [2:0] OP_VEL_B = 3'd4;
  localparam logic [2:0] OP_ACC_A = 3'd5;
  localparam logic [2:0] OP_LAST  = OP_ACC_A;

  typedef struct packed {
    logic [31:0] tick_period;
    logic [31:0] hit_time;
    logic [31:0] return_time;
    logic [31:0] rest_position;
  } cfg_t;

  typedef struct packed {
    logic       load;  // store coefficients, clear time
    logic       sel;   // pick segment and local time
    logic       mul;   // register product
    logic       acc;   // scale, saturate, add
    logic       fin;   // write output register, advance time (clear it at rest)
    logic [2:0] op;
  } ctl_cmd_t;

  typedef struct packed {
    logic rest;        // current time is past both segments
  } dp_status_t;

  // Saturate a 40-bit signed value to 32 bits
  function automatic logic [31:0] sat32(input logic [39:0] v);
    logic [31:0] r;
    if ((v[39:31] == 9'h000) || (v[39:31] == 9'h1FF)) begin
      r = v[31:0];
    end else if (v[39]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

[src/cti_ctrl.sv]
// Sequencing state machine for the cubic trajectory interpolator.
module cti_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_action,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  cti_pkg::dp_status_t    status,
  output cti_pkg::ctl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_action) begin
            state_nxt = S_SEL;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SEL: begin
        cmd.sel = 1'b1;
        op_nxt  = cti_pkg::OP_POS_A;
        state_nxt = status.rest ? S_DONE : S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (op_r == cti_pkg::OP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          op_nxt    = op_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.fin ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= cti_pkg::OP_POS_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_tick_starts_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_action) |=> (state_r == S_SEL))
    else $error("accepted tick did not start evaluation");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without finishing evaluation");

  a_op_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_ACC) |-> (op_r <= cti_pkg::OP_LAST))
    else $error("step counter out of range");

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> out_free)
    else $error("result written over an untaken one");

endmodule

[src/cti_datapath.sv]
// Coefficient store, time keeping and shared multiply-accumulate unit.
module cti_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cti_pkg::cfg_t          cfg,
  input  cti_pkg::ctl_cmd_t      cmd,
  output cti_pkg::dp_status_t    status,
  input  logic [31:0]            in_hit_cubic,
  input  logic [31:0]            in_hit_square,
  input  logic [31:0]            in_hit_linear,
  input  logic [31:0]            in_hit_offset,
  input  logic [31:0]            in_ret_cubic,
  input  logic [31:0]            in_ret_square,
  input  logic [31:0]            in_ret_linear,
  input  logic [31:0]            in_ret_offset,
  output logic [31:0]            out_position,
  output logic [31:0]            out_velocity,
  output logic [31:0]            out_acceleration,
  output logic                   out_in_motion,
  output logic [1:0]             out_phase
);

  logic [31:0] coef_r [cti_pkg::NumCoef];
  logic [31:0] elapsed_r;
  logic [31:0] u_r;
  logic [1:0]  phase_r;
  logic [63:0] prod_r;
  logic [31:0] h_r, pos_r, vel_r, acc_r;
  logic [31:0] o_pos_r, o_vel_r, o_acc_r;
  logic        o_motion_r;
  logic [1:0]  o_phase_r;

  logic        in_hit, in_ret;
  logic [32:0] seg_end;
  logic [32:0] time_sum;
  logic [31:0] c3, c2, c1, c0;
  logic [31:0] c3x3, c3x6, c2x2;
  logic [31:0] mul_a, add_b;
  logic [31:0] scaled;
  logic [31:0] acc_val;

  assign seg_end = {1'b0, cfg.hit_time} + {1'b0, cfg.return_time};
  assign in_hit  = (elapsed_r <= cfg.hit_time);
  assign in_ret  = ({1'b0, elapsed_r} <= seg_end);
  assign status.rest = !in_hit && !in_ret;

  assign time_sum = {1'b0, elapsed_r} + {1'b0, cfg.tick_period};

  // Segment coefficients: hit at 0..3, return at 4..7
  assign c3 = (phase_r == cti_pkg::PHASE_RET) ? coef_r[4] : coef_r[0];
  assign c2 = (phase_r == cti_pkg::PHASE_RET) ? coef_r[5] : coef_r[1];
  assign c1 = (phase_r == cti_pkg::PHASE_RET) ? coef_r[6] : coef_r[2];
  assign c0 = (phase_r == cti_pkg::PHASE_RET) ? coef_r[7] : coef_r[3];

  assign c3x3 = cti_pkg::sat32(40'($signed(c3)) * 40'sd3);
  assign c3x6 = cti_pkg::sat32(40'($signed(c3)) * 40'sd6);
  assign c2x2 = cti_pkg::sat32(40'($signed(c2)) * 40'sd2);

  always_comb begin
    case (cmd.op)
      cti_pkg::OP_POS_A: begin mul_a = c3;   add_b = c2;   end
      cti_pkg::OP_POS_B: begin mul_a = h_r;  add_b = c1;   end
      cti_pkg::OP_POS_C: begin mul_a = h_r;  add_b = c0;   end
      cti_pkg::OP_VEL_A: begin mul_a = c3x3; add_b = c2x2; end
      cti_pkg::OP_VEL_B: begin mul_a = h_r;  add_b = c1;   end
      cti_pkg::OP_ACC_A: begin mul_a = c3x6; add_b = c2x2; end
      default:           begin mul_a = '0;   add_b = '0;   end
    endcase
  end

  // Arithmetic shift of the product rounds toward minus infinity
  assign scaled  = cti_pkg::sat32(prod_r[63:24]);
  assign acc_val = cti_pkg::sat32(40'($signed(scaled)) + 40'($signed(add_b)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cti_pkg::NumCoef; i++) begin
        coef_r[i] <= '0;
      end
      elapsed_r <= '0;
      phase_r   <= cti_pkg::PHASE_HIT;
    end else begin
      if (cmd.load) begin
        coef_r[0] <= in_hit_cubic;
        coef_r[1] <= in_hit_square;
        coef_r[2] <= in_hit_linear;
        coef_r[3] <= in_hit_offset;
        coef_r[4] <= in_ret_cubic;
        coef_r[5] <= in_ret_square;
        coef_r[6] <= in_ret_linear;
        coef_r[7] <= in_ret_offset;
        elapsed_r <= '0;
      end
      if (cmd.sel) begin
        phase_r <= in_hit ? cti_pkg::PHASE_HIT :
                   (in_ret ? cti_pkg::PHASE_RET : cti_pkg::PHASE_REST);
      end
      if (cmd.fin) begin
        if (phase_r == cti_pkg::PHASE_REST) begin
          elapsed_r <= '0;
        end else begin
          elapsed_r <= time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      u_r <= in_hit ? elapsed_r : (elapsed_r - cfg.hit_time);
    end
    if (cmd.mul) begin
      prod_r <= $signed({{32{mul_a[31]}}, mul_a}) * $signed({32'b0, u_r});
    end
    if (cmd.acc) begin
      case (cmd.op)
        cti_pkg::OP_POS_C: pos_r <= acc_val;
        cti_pkg::OP_VEL_B: vel_r <= acc_val;
        cti_pkg::OP_ACC_A: acc_r <= acc_val;
        default:           h_r   <= acc_val;
      endcase
    end
    if (cmd.fin) begin
      if (phase_r == cti_pkg::PHASE_REST) begin
        o_pos_r    <= cfg.rest_position;
        o_vel_r    <= '0;
        o_acc_r    <= '0;
        o_motion_r <= 1'b0;
      end else begin
        o_pos_r    <= pos_r;
        o_vel_r    <= vel_r;
        o_acc_r    <= acc_r;
        o_motion_r <= 1'b1;
      end
      o_phase_r <= phase_r;
    end
  end

  assign out_position     = o_pos_r;
  assign out_velocity     = o_vel_r;
  assign out_acceleration = o_acc_r;
  assign out_in_motion    = o_motion_r;
  assign out_phase        = o_phase_r;

endmodule

[src/cubic_trajectory_interpolator_top.sv]
// A tick transfer steps through SEL, six multiply-accumulate steps (each a MUL then ACC state
// through the one shared 32x32 multiplier) and DONE, which writes the output register; past
// both segments SEL goes straight to DONE. No new item is taken until IDLE; a load gives no result.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low): controller idle, output empty, coefficients and time
// cleared, configuration registers at their defaults.
module cubic_trajectory_interpolator_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [31:0]               in_hit_cubic,
  input  logic [31:0]               in_hit_square,
  input  logic [31:0]               in_hit_linear,
  input  logic [31:0]               in_hit_offset,
  input  logic [31:0]               in_ret_cubic,
  input  logic [31:0]               in_ret_square,
  input  logic [31:0]               in_ret_linear,
  input  logic [31:0]               in_ret_offset,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_position,
  output logic [31:0]               out_velocity,
  output logic [31:0]               out_acceleration,
  output logic                      out_in_motion,
  output logic [1:0]                out_phase,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cti_pkg::AddrW-1:0] paddr,
  input  logic [cti_pkg::DataW-1:0] pwdata,
  output logic [cti_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  cti_pkg::cfg_t       cfg_r;
  cti_pkg::ctl_cmd_t   cmd;
  cti_pkg::dp_status_t status;
  logic                cfg_wr;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period   <= cti_pkg::TICK_PERIOD_RST;
      cfg_r.hit_time      <= cti_pkg::HIT_TIME_RST;
      cfg_r.return_time   <= cti_pkg::RETURN_TIME_RST;
      cfg_r.rest_position <= cti_pkg::REST_POSITION_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        cti_pkg::REG_TICK_PERIOD:   cfg_r.tick_period   <= pwdata;
        cti_pkg::REG_HIT_TIME:      cfg_r.hit_time      <= pwdata;
        cti_pkg::REG_RETURN_TIME:   cfg_r.return_time   <= pwdata;
        cti_pkg::REG_REST_POSITION: cfg_r.rest_position <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cti_pkg::REG_TICK_PERIOD:   prdata = cfg_r.tick_period;
      cti_pkg::REG_HIT_TIME:      prdata = cfg_r.hit_time;
      cti_pkg::REG_RETURN_TIME:   prdata = cfg_r.return_time;
      cti_pkg::REG_REST_POSITION: prdata = cfg_r.rest_position;
      default:                    prdata = '0;
    endcase
  end

  cti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cti_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .status           (status),
    .in_hit_cubic     (in_hit_cubic),
    .in_hit_square    (in_hit_square),
    .in_hit_linear    (in_hit_linear),
    .in_hit_offset    (in_hit_offset),
    .in_ret_cubic     (in_ret_cubic),
    .in_ret_square    (in_ret_square),
    .in_ret_linear    (in_ret_linear),
    .in_ret_offset    (in_ret_offset),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .out_acceleration (out_acceleration),
    .out_in_motion    (out_in_motion),
    .out_phase        (out_phase)
  );

endmodule
